// ===== src/vector_normalizer_assert.svh =====
// Assertion macros used by the checker of the vector normaliser.
`ifndef VECTOR_NORMALIZER_ASSERT_SVH
`define VECTOR_NORMALIZER_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define VN_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent.
`define VN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/vn_pkg.sv =====
// Package with constants, types and width functions of the vector normaliser.
package vn_pkg;

    localparam int MAX_LEN_DEFAULT = 16;
    localparam int ELEM_W          = 16;
    localparam int FRAC_BITS       = 15;

    localparam logic signed [ELEM_W-1:0] UNIT_ONE = 16'sh7FFF;
    localparam logic signed [ELEM_W-1:0] UNIT_MIN = 16'sh8000;

    typedef struct packed {
        logic load;
        logic sqrt_init;
        logic sqrt_step;
        logic rd_en;
        logic prep;
        logic div_step;
        logic div_last;
        logic clear_vec;
        logic first;
    } vn_cmd_t;

    typedef struct packed {
        logic zero;
        logic skip_div;
    } vn_status_t;

    function automatic int sum_width(input int max_len);
        return 31 + $clog2(max_len);
    endfunction

    function automatic int root_width(input int max_len);
        return (sum_width(max_len) + 1) >> 1;
    endfunction

    function automatic int idx_width(input int max_len);
        return (max_len > 1) ? $clog2(max_len) : 1;
    endfunction

    function automatic int cnt_width(input int max_len);
        return $clog2(max_len + 1);
    endfunction

endpackage

// ===== src/vn_in_if.sv =====
// Input channel interface: one vector component per word.
interface vn_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [vn_pkg::ELEM_W-1:0]  element;
    logic                              last_element;

    modport source (output valid, output element, output last_element, input ready);
    modport sink   (input valid, input element, input last_element, output ready);
endinterface

// ===== src/vn_out_if.sv =====
// Output channel interface: one normalised component per word.
interface vn_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [vn_pkg::ELEM_W-1:0]  unit_component;
    logic                              last_output;
    logic                              was_zero;

    modport source (output valid, output unit_component, output last_output,
                    output was_zero, input ready);
    modport sink   (input valid, input unit_component, input last_output,
                    input was_zero, output ready);
endinterface

// ===== src/vn_datapath.sv =====
// Datapath: component store, square sum, iterative square root and serial divider.
module vn_datapath #(
    parameter int  MAX_LEN = vn_pkg::MAX_LEN_DEFAULT,
    localparam int IDX_W   = vn_pkg::idx_width(MAX_LEN)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vn_pkg::vn_cmd_t                   cmd,
    input  logic [IDX_W-1:0]                  addr,
    input  logic signed [vn_pkg::ELEM_W-1:0]  element,
    output vn_pkg::vn_status_t                status,
    output logic signed [vn_pkg::ELEM_W-1:0]  unit_component
);
    import vn_pkg::*;

    localparam int SUM_W  = sum_width(MAX_LEN);
    localparam int ROOT_W = root_width(MAX_LEN);

    logic signed [ELEM_W-1:0] store_mem [MAX_LEN];
    logic signed [ELEM_W-1:0] rd_data_reg;

    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum_next;
    logic                  zero_reg;
    logic [2*ROOT_W-1:0]   sq_v_reg;
    logic [ROOT_W+1:0]     sq_rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [ROOT_W-1:0]     div_rem_reg;
    logic [FRAC_BITS-1:0]  quo_reg;
    logic [FRAC_BITS-1:0]  quo_next;
    logic                  neg_reg;
    logic signed [ELEM_W-1:0] out_reg;

    logic signed [2*ELEM_W-1:0] sq_prod;
    logic [ROOT_W+3:0]     rem_sh;
    logic [ROOT_W+3:0]     trial;
    logic [ROOT_W+3:0]     rem_diff;
    logic                  rem_ge;
    logic [ROOT_W-1:0]     mag;
    logic [ELEM_W-1:0]     abs_val;
    logic                  sat;
    logic [ROOT_W:0]       d_sh;
    logic [ROOT_W:0]       d_diff;
    logic                  d_ge;

    assign sq_prod  = element * element;
    assign sum_next = sum_reg + SUM_W'(sq_prod[2*ELEM_W-2:0]);

    assign rem_sh   = {sq_rem_reg, sq_v_reg[2*ROOT_W-1 -: 2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign rem_ge   = rem_sh >= trial;
    assign rem_diff = rem_sh - trial;

    assign mag      = (root_reg == '0) ? ROOT_W'(1) : root_reg;
    assign abs_val  = rd_data_reg[ELEM_W-1] ? (~rd_data_reg + 1'b1) : rd_data_reg;
    assign sat      = ROOT_W'(abs_val) >= mag;

    assign d_sh     = {div_rem_reg, 1'b0};
    assign d_ge     = d_sh >= {1'b0, mag};
    assign d_diff   = d_sh - {1'b0, mag};
    assign quo_next = {quo_reg[FRAC_BITS-2:0], d_ge};

    assign status.zero     = zero_reg;
    assign status.skip_div = zero_reg | sat;
    assign unit_component  = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            store_mem[addr] <= element;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= store_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            zero_reg <= 1'b1;
        end
        else if (cmd.clear_vec)
        begin
            sum_reg  <= '0;
            zero_reg <= 1'b1;
        end
        else if (cmd.load)
        begin
            sum_reg  <= sum_next;
            zero_reg <= zero_reg & (element == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            sq_v_reg   <= (2*ROOT_W)'(sum_next);
            sq_rem_reg <= '0;
            root_reg   <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sq_v_reg <= {sq_v_reg[2*ROOT_W-3:0], 2'b00};
            if (rem_ge)
            begin
                sq_rem_reg <= rem_diff[ROOT_W+1:0];
                root_reg   <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg <= rem_sh[ROOT_W+1:0];
                root_reg   <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            neg_reg     <= rd_data_reg[ELEM_W-1];
            div_rem_reg <= ROOT_W'(abs_val);
            quo_reg     <= '0;
            if (zero_reg)
            begin
                out_reg <= cmd.first ? UNIT_ONE : '0;
            end
            else if (sat)
            begin
                out_reg <= rd_data_reg[ELEM_W-1] ? UNIT_MIN : UNIT_ONE;
            end
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= d_ge ? d_diff[ROOT_W-1:0] : d_sh[ROOT_W-1:0];
            quo_reg     <= quo_next;
            if (cmd.div_last)
            begin
                out_reg <= neg_reg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
            end
        end
    end

endmodule

// ===== src/vn_control.sv =====
// Controller: sequences loading, square root, division and emission of a vector.
module vn_control #(
    parameter int  MAX_LEN = vn_pkg::MAX_LEN_DEFAULT,
    localparam int IDX_W   = vn_pkg::idx_width(MAX_LEN)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_last,
    output vn_pkg::vn_cmd_t     cmd,
    output logic [IDX_W-1:0]    addr,
    input  vn_pkg::vn_status_t  status
);
    import vn_pkg::*;

    localparam int ROOT_W = root_width(MAX_LEN);
    localparam int CNT_W  = cnt_width(MAX_LEN);
    localparam int STEP_W = $clog2(ROOT_W);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_SQRT = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_DROP = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic             drop_reg, drop_next;

    logic [CNT_W-1:0] count_inc;
    logic             close_vec;
    logic             last_idx;

    assign count_inc = count_reg + CNT_W'(1);
    assign close_vec = in_last || (count_inc == CNT_W'(MAX_LEN));
    assign last_idx  = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign out_last  = last_idx;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        drop_next  = drop_reg;
        cmd        = '0;
        cmd.first  = (idx_reg == '0);
        addr       = idx_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                addr     = count_reg[IDX_W-1:0];
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    count_next = count_inc;
                    if (close_vec)
                    begin
                        cmd.sqrt_init = 1'b1;
                        step_next     = '0;
                        drop_next     = !in_last;
                        state_next    = S_SQRT;
                    end
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    idx_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep  = 1'b1;
                step_next = '0;
                if (status.skip_div)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(FRAC_BITS - 1))
                begin
                    cmd.div_last = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (last_idx)
                    begin
                        cmd.clear_vec = 1'b1;
                        count_next    = '0;
                        state_next    = drop_reg ? S_DROP : S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            S_DROP:
            begin
                in_ready = 1'b1;
                if (in_valid && in_last)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

// ===== src/vector_normalizer.sv =====
// Vector normaliser: scales a vector of signed components to a unit vector in Q1.15.
//
// Components arrive on in_ch, one word each, at one per cycle while the block loads.
// A vector closes on last_element or when MAX_LEN components have arrived; after a
// vector closed by length, further words are taken and dropped up to one with
// last_element set. The magnitude is the floor square root of the sum of squares,
// found in an iterative unit that takes two bits of the sum per step. Each component
// is then read from the store and divided by a restoring divider, one quotient bit a
// cycle; division is skipped where the result saturates or the vector is all zero.
// Results leave on out_ch with last_output on the final word and was_zero on every
// word of an all-zero vector. No input is taken while a vector is being emitted. A
// stalled receiver holds the current result word and the whole block with it. Reset
// empties the vector and returns the block to loading; the store needs no clearing.
module vector_normalizer #(
    parameter int MAX_LEN = vn_pkg::MAX_LEN_DEFAULT
) (
    input logic     clk,
    input logic     rst_n,
    vn_in_if.sink   in_ch,
    vn_out_if.source out_ch
);
    import vn_pkg::*;

    localparam int IDX_W = idx_width(MAX_LEN);

    vn_cmd_t          cmd;
    vn_status_t       status;
    logic [IDX_W-1:0] addr;

    vn_control #(
        .MAX_LEN (MAX_LEN)
    ) u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_last   (in_ch.last_element),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_last  (out_ch.last_output),
        .cmd       (cmd),
        .addr      (addr),
        .status    (status)
    );

    vn_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .addr           (addr),
        .element        (in_ch.element),
        .status         (status),
        .unit_component (out_ch.unit_component)
    );

    assign out_ch.was_zero = status.zero;

endmodule

// ===== src/vn_checker.sv =====
// Port-level checker of the vector normaliser and its binding to the top level.
`include "vector_normalizer_assert.svh"

module vn_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [vn_pkg::ELEM_W-1:0]  unit_component,
    input logic                              last_output,
    input logic                              was_zero
);
    import vn_pkg::*;

    `VN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(unit_component) && $stable(last_output) && $stable(was_zero),
        "Stalled result word changed")

    `VN_ASSERT_SAME(a_no_overlap, in_ready, !out_valid,
        "Input taken while a result word is offered")

    `VN_ASSERT_SAME(a_zero_value, out_valid && was_zero,
        unit_component == UNIT_ONE || unit_component == '0,
        "All-zero vector gave a value other than one or zero")

    `VN_ASSERT_NEXT(a_end_of_vector, out_valid && out_ready && last_output, !out_valid,
        "Result word offered after the final word of a vector")

endmodule

bind vector_normalizer vn_checker u_vn_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .unit_component (out_ch.unit_component),
    .last_output    (out_ch.last_output),
    .was_zero       (out_ch.was_zero)
);

// ===== sim/tb_vector_normalizer.sv =====
// Testbench for the vector normaliser: random and directed vectors checked against a predictor.
`timescale 1ns / 100ps

module tb_vector_normalizer;
    import vn_pkg::*;

    localparam int VEC_MAX     = MAX_LEN_DEFAULT;
    localparam int ITEM_TARGET = 320;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 60;

    class norm_scoreboard;
        typedef struct {
            logic signed [ELEM_W-1:0] unit;
            logic                     last;
            logic                     zero;
        } unit_word_t;

        unit_word_t               expected_q[$];
        logic signed [ELEM_W-1:0] held[VEC_MAX];
        logic [35:0]              square_acc;
        int unsigned              held_count;
        bit                       all_zero;
        int                       errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            square_acc = '0;
            held_count = 0;
            all_zero   = 1'b1;
        endfunction

        function longint unsigned floor_root(logic [35:0] s);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 18; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= s)
                    r = t;
            end
            return r;
        endfunction

        function logic signed [ELEM_W-1:0] unit_scale(logic signed [ELEM_W-1:0] x,
                                                      longint unsigned mag);
            longint unsigned abs_x;
            longint unsigned q;
            abs_x = (x < 0) ? longint'(-longint'(x)) : longint'(x);
            q = (abs_x << FRAC_BITS) / mag;
            if (x < 0)
            begin
                if (q > 32768)
                    q = 32768;
                return 16'(65536 - q);
            end
            if (q > 32767)
                q = 32767;
            return 16'(q);
        endfunction

        function void note_component(logic signed [ELEM_W-1:0] e, logic l);
            longint          sq;
            longint unsigned root;
            unit_word_t      w;
            if (held_count >= VEC_MAX)
            begin
                if (l)
                    restart();
                return;
            end
            held[held_count] = e;
            sq = longint'(e) * longint'(e);
            square_acc += sq[35:0];
            if (e != 0)
                all_zero = 1'b0;
            held_count++;
            if (!l && held_count < VEC_MAX)
                return;
            root = floor_root(square_acc);
            if (root == 0)
                root = 1;
            for (int i = 0; i < held_count; i++)
            begin
                if (all_zero)
                    w.unit = (i == 0) ? UNIT_ONE : '0;
                else
                    w.unit = unit_scale(held[i], root);
                w.last = (i == held_count - 1);
                w.zero = all_zero;
                expected_q.push_back(w);
            end
            if (l)
                restart();
            else
            begin
                square_acc = '0;
                all_zero   = 1'b1;
            end
        endfunction

        function void flag(string field, int exp_val, int act_val);
            errors++;
            $display("%0t: %s expected %0d, actual %0d", $time, field, exp_val, act_val);
        endfunction

        function void check_word(logic signed [ELEM_W-1:0] unit, logic last, logic zero);
            unit_word_t w;
            if (expected_q.size() == 0)
            begin
                flag("unexpected word, unit_component", 0, int'(unit));
                return;
            end
            w = expected_q.pop_front();
            if (unit !== w.unit)
                flag("unit_component", int'(w.unit), int'(unit));
            if (last !== w.last)
                flag("last_output", int'(w.last), int'(last));
            if (zero !== w.zero)
                flag("was_zero", int'(w.zero), int'(zero));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    vn_in_if  in_ch();
    vn_out_if out_ch();

    vector_normalizer #(.MAX_LEN(VEC_MAX)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    norm_scoreboard sb;
    bit             tx_quiet;
    bit             rx_quiet;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic send_word(input logic signed [ELEM_W-1:0] e, input logic l);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 13);
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid        <= 1'b1;
        in_ch.element      <= e;
        in_ch.last_element <= l;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_component(e, l);
    endtask

    function automatic logic signed [ELEM_W-1:0] draw_component(int flavour);
        int v;
        case (flavour)
            0: v = int'($urandom_range(0, 65535)) - 32768;
            1: v = int'($urandom_range(0, 16)) - 8;
            2:
            begin
                case ($urandom_range(0, 4))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = -1;
                    3: v = 1;
                    default: v = 0;
                endcase
            end
            default: v = int'($urandom_range(0, 2047)) - 1024;
        endcase
        return 16'(v);
    endfunction

    initial
    begin
        int hold;
        out_ch.ready = 1'b0;
        rx_quiet     = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                rx_quiet = !rx_quiet;
            hold = rx_quiet ? 0 : $urandom_range(0, 13);
            repeat (hold)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge clk);
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (out_ch.valid !== 1'b1);
            sb.check_word(out_ch.unit_component, out_ch.last_output, out_ch.was_zero);
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int counted;
        int total;
        int flavour;
        bit zero_vec;
        sb                 = new();
        tx_quiet           = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.element      = '0;
        in_ch.last_element = 1'b0;
        rst_n              = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(16'sd32767, 1'b1);
        send_word(-16'sd32768, 1'b1);
        send_word(16'sd0, 1'b1);
        send_word(16'sd3, 1'b0);
        send_word(-16'sd4, 1'b1);
        send_word(16'sd0, 1'b0);
        send_word(16'sd0, 1'b0);
        send_word(16'sd0, 1'b1);
        // A full vector with no closing flag is emitted by length; the next word is dropped.
        repeat (VEC_MAX) send_word(-16'sd32768, 1'b0);
        send_word(16'sd32767, 1'b1);

        counted = 9 + VEC_MAX;
        while (counted < ITEM_TARGET)
        begin
            flavour  = $urandom_range(0, 3);
            zero_vec = ($urandom_range(0, 9) == 0);
            tx_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0)
                total = VEC_MAX + $urandom_range(1, 4);
            else if ($urandom_range(0, 1) == 0)
                total = $urandom_range(1, 4);
            else
                total = $urandom_range(1, VEC_MAX);
            for (int i = 0; i < total; i++)
                send_word(zero_vec ? '0 : draw_component(flavour), i == total - 1);
            counted += total;
        end
        @(negedge clk);
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
